### rtl/core/clce_pkg.sv
`timescale 1ns / 1ps
package clce_pkg;

    localparam int CAPACITY   = 16;
    localparam int ELEM_WIDTH = 32;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Operation codes carried on s_tuser
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_REM  = 2'd1;
    localparam logic [1:0] OP_ADV  = 2'd2;
    localparam logic [1:0] OP_DUMP = 2'd3;

    // Result status codes carried on m_tuser
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Datapath command codes
    localparam logic [3:0] CMD_NONE     = 4'd0;
    localparam logic [3:0] CMD_ACCEPT   = 4'd1;
    localparam logic [3:0] CMD_ADD      = 4'd2;
    localparam logic [3:0] CMD_ADD_LINK = 4'd3;
    localparam logic [3:0] CMD_REM      = 4'd4;
    localparam logic [3:0] CMD_REM_FREE = 4'd5;
    localparam logic [3:0] CMD_ADV      = 4'd6;
    localparam logic [3:0] CMD_ADV_SET  = 4'd7;
    localparam logic [3:0] CMD_DUMP_RD  = 4'd8;
    localparam logic [3:0] CMD_DUMP_OUT = 4'd9;
    localparam logic [3:0] CMD_EMIT     = 4'd10;

    typedef struct packed {
        logic [3:0] code;
        logic [1:0] op;
        logic [1:0] status;
    } clce_cmd_t;

    typedef struct packed {
        logic empty;     // list holds no nodes
        logic full;      // free list exhausted
        logic single;    // node after cursor is the cursor itself
        logic fin;       // current dump beat is the final one
        logic out_free;  // output register can take a beat
    } clce_stat_t;

endpackage

### rtl/core/clce_ctrl.sv
`timescale 1ns / 1ps
module clce_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [1:0]             s_op,
    input  clce_pkg::clce_stat_t   stat,
    output clce_pkg::clce_cmd_t    cmd
);
    import clce_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ADD      = 4'd1;
    localparam logic [3:0] S_ADD_LINK = 4'd2;
    localparam logic [3:0] S_REM      = 4'd3;
    localparam logic [3:0] S_REM_FREE = 4'd4;
    localparam logic [3:0] S_ADV      = 4'd5;
    localparam logic [3:0] S_ADV_SET  = 4'd6;
    localparam logic [3:0] S_DUMP_RD  = 4'd7;
    localparam logic [3:0] S_DUMP_OUT = 4'd8;
    localparam logic [3:0] S_EMIT     = 4'd9;

    logic [3:0] state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // Sequencing and command decode
    always_comb begin
        state_next = state_reg;
        cmd.code   = CMD_NONE;
        cmd.op     = s_op;
        cmd.status = ST_OK;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.code = CMD_ACCEPT;
                    case (s_op)
                        OP_ADD: begin
                            if (stat.full) begin
                                cmd.status = ST_FULL;
                                state_next = S_EMIT;
                            end else begin
                                state_next = S_ADD;
                            end
                        end
                        OP_REM: begin
                            if (stat.empty) begin
                                cmd.status = ST_EMPTY;
                                state_next = S_EMIT;
                            end else if (stat.single) begin
                                state_next = S_REM_FREE;
                            end else begin
                                state_next = S_REM;
                            end
                        end
                        OP_ADV: begin
                            if (stat.empty) begin
                                cmd.status = ST_EMPTY;
                                state_next = S_EMIT;
                            end else begin
                                state_next = S_ADV;
                            end
                        end
                        default: begin
                            state_next = stat.empty ? S_EMIT : S_DUMP_RD;
                        end
                    endcase
                end
            end
            S_ADD: begin
                cmd.code   = CMD_ADD;
                state_next = stat.empty ? S_EMIT : S_ADD_LINK;
            end
            S_ADD_LINK: begin
                cmd.code   = CMD_ADD_LINK;
                state_next = S_EMIT;
            end
            S_REM: begin
                cmd.code   = CMD_REM;
                state_next = S_REM_FREE;
            end
            S_REM_FREE: begin
                cmd.code   = CMD_REM_FREE;
                state_next = S_EMIT;
            end
            S_ADV: begin
                cmd.code   = CMD_ADV;
                state_next = S_ADV_SET;
            end
            S_ADV_SET: begin
                cmd.code   = CMD_ADV_SET;
                state_next = S_EMIT;
            end
            S_DUMP_RD: begin
                cmd.code   = CMD_DUMP_RD;
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                if (stat.out_free) begin
                    cmd.code   = CMD_DUMP_OUT;
                    state_next = stat.fin ? S_IDLE : S_DUMP_RD;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.code   = CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/clce_dpath.sv
`timescale 1ns / 1ps
module clce_dpath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [clce_pkg::ELEM_WIDTH-1:0]   s_value,
    input  clce_pkg::clce_cmd_t               cmd,
    output clce_pkg::clce_stat_t              stat,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [clce_pkg::ELEM_WIDTH-1:0]   m_front,
    output logic [clce_pkg::ELEM_WIDTH-1:0]   m_back,
    output logic [clce_pkg::ELEM_WIDTH-1:0]   m_item,
    output logic                              m_empty,
    output logic [1:0]                        m_status,
    output logic                              m_last
);
    import clce_pkg::*;

    // Link table: memory plus per-entry valid bits for the reset pattern
    logic [IDX_W-1:0]      link_mem [CAPACITY];
    logic [CAPACITY-1:0]   link_vld_reg;
    logic [IDX_W-1:0]      link_rd_reg;
    logic                  link_we, link_re;
    logic [IDX_W-1:0]      link_wa, link_wd, link_ra;

    // Node store: contents undefined until written
    logic [ELEM_WIDTH-1:0] node_mem [CAPACITY];
    logic [ELEM_WIDTH-1:0] node_rd_reg;
    logic                  node_we, node_re;
    logic [IDX_W-1:0]      node_wa, node_ra;

    // List state
    logic [IDX_W-1:0]      free_head_reg;
    logic [CNT_W-1:0]      free_count_reg;
    logic [IDX_W-1:0]      cur_reg;
    logic [IDX_W-1:0]      front_reg;
    logic                  empty_reg;
    logic [ELEM_WIDTH-1:0] front_word_reg;
    logic [ELEM_WIDTH-1:0] back_word_reg;

    // Per-item working registers
    logic [ELEM_WIDTH-1:0] val_reg;
    logic [1:0]            status_reg;
    logic [IDX_W-1:0]      tmp_reg;
    logic [IDX_W-1:0]      walk_reg;
    logic [CNT_W-1:0]      k_reg;
    logic                  fin_reg;

    // Output register
    logic                  out_valid_reg;
    logic [ELEM_WIDTH-1:0] out_front_reg, out_back_reg, out_item_reg;
    logic                  out_empty_reg, out_last_reg;
    logic [1:0]            out_status_reg;

    logic [CNT_W-1:0]      used_raw, used;
    logic                  out_load;
    logic [IDX_W-1:0]      link_dflt;

    assign used_raw = CNT_W'(CAPACITY) - free_count_reg;
    assign used     = (used_raw == '0) ? CNT_W'(CAPACITY) : used_raw;

    assign stat.empty    = empty_reg;
    assign stat.full     = (free_count_reg == '0);
    assign stat.single   = (front_reg == cur_reg);
    assign stat.fin      = fin_reg;
    assign stat.out_free = !out_valid_reg || m_ready;

    assign out_load = (cmd.code == CMD_EMIT) || (cmd.code == CMD_DUMP_OUT);

    // Memory port control
    always_comb begin
        link_we = 1'b0;
        link_wa = cur_reg;
        link_wd = tmp_reg;
        link_re = 1'b0;
        link_ra = front_reg;
        node_we = 1'b0;
        node_wa = free_head_reg;
        node_re = 1'b0;
        node_ra = link_rd_reg;
        case (cmd.code)
            CMD_ACCEPT: begin
                link_re = (cmd.op == OP_ADD) || (cmd.op == OP_REM) || (cmd.op == OP_ADV);
                link_ra = (cmd.op == OP_ADD) ? free_head_reg : front_reg;
            end
            CMD_ADD: begin
                node_we = 1'b1;
                link_we = 1'b1;
                link_wa = free_head_reg;
                link_wd = empty_reg ? free_head_reg : front_reg;
            end
            CMD_ADD_LINK: begin
                link_we = 1'b1;
                link_wa = cur_reg;
                link_wd = tmp_reg;
            end
            CMD_REM: begin
                link_we = 1'b1;
                link_wa = cur_reg;
                link_wd = link_rd_reg;
                node_re = 1'b1;
                node_ra = link_rd_reg;
            end
            CMD_REM_FREE: begin
                link_we = 1'b1;
                link_wa = front_reg;
                link_wd = free_head_reg;
            end
            CMD_ADV: begin
                node_re = 1'b1;
                node_ra = link_rd_reg;
            end
            CMD_DUMP_RD: begin
                link_re = 1'b1;
                link_ra = walk_reg;
                node_re = 1'b1;
                node_ra = walk_reg;
            end
            default: begin
            end
        endcase
    end

    // Reset pattern of the link table: entry i points at i + 1, wrapping
    assign link_dflt = (link_ra == IDX_W'(CAPACITY - 1)) ? '0 : link_ra + 1'b1;

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        if (link_re) begin
            link_rd_reg <= link_vld_reg[link_ra] ? link_mem[link_ra] : link_dflt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_vld_reg <= '0;
        end else if (link_we) begin
            link_vld_reg[link_wa] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[node_wa] <= val_reg;
        end
        if (node_re) begin
            node_rd_reg <= node_mem[node_ra];
        end
    end

    // List state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg  <= '0;
            free_count_reg <= CNT_W'(CAPACITY);
            cur_reg        <= '0;
            front_reg      <= '0;
            empty_reg      <= 1'b1;
        end else begin
            case (cmd.code)
                CMD_ADD: begin
                    free_head_reg  <= link_rd_reg;
                    free_count_reg <= free_count_reg - 1'b1;
                    front_reg      <= free_head_reg;
                    if (empty_reg) begin
                        cur_reg   <= free_head_reg;
                        empty_reg <= 1'b0;
                    end
                end
                CMD_REM_FREE: begin
                    free_head_reg <= front_reg;
                    if (free_count_reg < CNT_W'(CAPACITY)) begin
                        free_count_reg <= free_count_reg + 1'b1;
                    end
                    if (front_reg == cur_reg) begin
                        empty_reg <= 1'b1;
                    end else begin
                        front_reg <= tmp_reg;
                    end
                end
                CMD_ADV: begin
                    cur_reg <= front_reg;
                end
                CMD_ADV_SET: begin
                    front_reg <= tmp_reg;
                end
                default: begin
                end
            endcase
        end
    end

    // Cached words and per-item working registers
    always_ff @(posedge aclk) begin
        case (cmd.code)
            CMD_ACCEPT: begin
                val_reg    <= s_value;
                status_reg <= cmd.status;
                walk_reg   <= front_reg;
                k_reg      <= '0;
            end
            CMD_ADD: begin
                tmp_reg        <= free_head_reg;
                front_word_reg <= val_reg;
                if (empty_reg) begin
                    back_word_reg <= val_reg;
                end
            end
            CMD_REM: begin
                tmp_reg <= link_rd_reg;
            end
            CMD_REM_FREE: begin
                front_word_reg <= node_rd_reg;
            end
            CMD_ADV: begin
                tmp_reg       <= link_rd_reg;
                back_word_reg <= front_word_reg;
            end
            CMD_ADV_SET: begin
                front_word_reg <= node_rd_reg;
            end
            CMD_DUMP_RD: begin
                fin_reg <= (walk_reg == cur_reg) || ((k_reg + 1'b1) == used);
            end
            CMD_DUMP_OUT: begin
                walk_reg <= link_rd_reg;
                k_reg    <= k_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Output register: valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_front_reg  <= empty_reg ? '0 : front_word_reg;
            out_back_reg   <= empty_reg ? '0 : back_word_reg;
            out_empty_reg  <= empty_reg;
            if (cmd.code == CMD_DUMP_OUT) begin
                out_item_reg   <= node_rd_reg;
                out_status_reg <= ST_OK;
                out_last_reg   <= fin_reg;
            end else begin
                out_item_reg   <= '0;
                out_status_reg <= status_reg;
                out_last_reg   <= 1'b1;
            end
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_front  = out_front_reg;
    assign m_back   = out_back_reg;
    assign m_item   = out_item_reg;
    assign m_empty  = out_empty_reg;
    assign m_status = out_status_reg;
    assign m_last   = out_last_reg;

endmodule

### rtl/core/circular_list_cursor_engine.sv
`timescale 1ns / 1ps
// Circular list with a cursor over a 16-entry node store. Each input beat is
// one operation (s_tuser: 0 add after cursor, 1 remove after cursor,
// 2 advance, 3 dump); each result beat reports the front word, the back word,
// the dumped word and an empty flag, with status on m_tuser (0 ok, 1 ignored
// on empty list, 2 add dropped on full store) and m_tlast on the final beat of
// an operation. One operation is worked at a time, and the next is accepted
// once its last result is in the output register. Add writes the node, then
// links it after the cursor (not for the first node); remove unlinks the node
// after the cursor (not for the only node), then frees it; advance moves the
// cursor, then loads the new front. A flagged operation or a dump of an empty
// list goes straight to its result; a dump reads, then outputs, each node.
// Dependent writes and node reads wait on the registered link table read.
module circular_list_cursor_engine (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // value
    input  logic [1:0]   s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // front_value, back_value, item_value, is_empty, zero fill
    output logic [1:0]   m_tuser,   // status
    output logic         m_tlast
);
    import clce_pkg::*;

    clce_cmd_t             cmd;
    clce_stat_t            stat;
    logic [ELEM_WIDTH-1:0] front_w, back_w, item_w;
    logic                  empty_w;

    clce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    clce_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_value  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_front  (front_w),
        .m_back   (back_w),
        .m_item   (item_w),
        .m_empty  (empty_w),
        .m_status (m_tuser),
        .m_last   (m_tlast)
    );

    assign m_tdata = {7'd0, empty_w, item_w, back_w, front_w};

endmodule
